[rtl/first_fit_max_tree_allocator_top_assert.svh]
// Assertion macros used by the checker file of the allocator.
`ifndef FIRST_FIT_MAX_TREE_ALLOCATOR_TOP_ASSERT_SVH
`define FIRST_FIT_MAX_TREE_ALLOCATOR_TOP_ASSERT_SVH

// Checked only while the block is out of reset.
`define FFMTA_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define FFMTA_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/ffmta_pkg.sv]
package ffmta_pkg;

    localparam int BINS       = 1024;
    localparam int VALUE_BITS = 32;
    localparam int LEVELS     = $clog2(BINS);
    localparam int LEAVES     = 1 << LEVELS;
    localparam int NODE_BITS  = LEVELS + 1;
    localparam int BIN_W      = 10;
    localparam int AMOUNT_W   = 32;
    localparam int ROOM_W     = 11;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_ALLOC = 1'b1;

    typedef logic [VALUE_BITS-1:0] t_value;
    typedef logic [NODE_BITS-1:0]  t_node;

endpackage

[rtl/ffmta_if.sv]
interface ffmta_req_if;
    import ffmta_pkg::*;

    logic                valid;
    logic                ready;
    logic                op;
    logic [BIN_W-1:0]    bin_index;
    logic [AMOUNT_W-1:0] amount;

    modport source (output valid, output op, output bin_index, output amount, input ready);
    modport sink   (input valid, input op, input bin_index, input amount, output ready);
endinterface

interface ffmta_rsp_if;
    import ffmta_pkg::*;

    logic              valid;
    logic              ready;
    logic [ROOM_W-1:0] room;
    logic              granted;

    modport source (output valid, output room, output granted, input ready);
    modport sink   (input valid, input room, input granted, output ready);
endinterface

[rtl/first_fit_max_tree_allocator_top.sv]
// An allocation reads the root, descends to the first bin that fits, writes that bin and
// updates every ancestor before its result is registered; when no bin fits, the result
// follows the root check. A load writes its bin, updates the ancestors and gives no
// result. One request at a time, accepted only while idle; a stalled result holds it busy.
// Reset: synchronous, active low. A clearing pass then writes zero to all 2*BINS
// tree nodes, one a cycle, while no request is accepted.
module first_fit_max_tree_allocator_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ffmta_req_if.sink   i_req,
    ffmta_rsp_if.source o_rsp
);
    import ffmta_pkg::*;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_LOAD,
        S_ROOT,
        S_CHECK,
        S_DESC,
        S_LEAF,
        S_UP,
        S_RESULT
    } t_state;

    t_state r_state, n_state;
    t_node  r_node, n_node;
    t_value r_val, n_val;
    t_value r_amt, n_amt;
    logic   r_alloc, n_alloc;
    logic [ROOM_W-1:0] r_room, n_room;
    logic   r_granted, n_granted;
    logic   r_out_valid, n_out_valid;
    logic [ROOM_W-1:0] r_out_room, n_out_room;
    logic   r_out_granted, n_out_granted;

    // Tree memory: node 1 is the root, nodes LEAVES..2*LEAVES-1 are the bins.
    t_value r_tree [2*LEAVES];
    t_value r_rdata;
    logic   mem_we;
    t_node  mem_waddr;
    t_value mem_wdata;
    t_node  mem_raddr;

    t_node  ancestor;
    t_node  sibling;
    t_node  child;
    t_value up_max;
    logic   go_left;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_tree[mem_waddr] <= mem_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_tree[mem_raddr];
    end

    always_comb begin
        ancestor = r_node >> 1;
        sibling  = r_node ^ t_node'(1);
        up_max   = (r_val >= r_rdata) ? r_val : r_rdata;
        go_left  = (r_rdata >= r_amt);
        child    = {r_node[NODE_BITS-2:0], ~go_left};

        n_state       = r_state;
        n_node        = r_node;
        n_val         = r_val;
        n_amt         = r_amt;
        n_alloc       = r_alloc;
        n_room        = r_room;
        n_granted     = r_granted;
        n_out_valid   = r_out_valid;
        n_out_room    = r_out_room;
        n_out_granted = r_out_granted;
        mem_we        = 1'b0;
        mem_waddr     = r_node;
        mem_wdata     = '0;
        mem_raddr     = r_node;

        if (r_out_valid && o_rsp.ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_CLEAR: begin
                mem_we = 1'b1;
                n_node = r_node + t_node'(1);
                if (&r_node) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_req.valid) begin
                    n_amt  = t_value'(i_req.amount);
                    n_node = t_node'(LEAVES) + t_node'(i_req.bin_index);
                    if (i_req.op == OP_ALLOC) begin
                        n_alloc = 1'b1;
                        n_state = S_ROOT;
                    end else if (32'(i_req.bin_index) < 32'(BINS)) begin
                        n_alloc = 1'b0;
                        n_state = S_LOAD;
                    end
                end
            end
            S_LOAD: begin
                mem_we    = 1'b1;
                mem_wdata = r_amt;
                n_val     = r_amt;
                mem_raddr = sibling;
                n_state   = S_UP;
            end
            S_ROOT: begin
                mem_raddr = t_node'(1);
                n_state   = S_CHECK;
            end
            S_CHECK: begin
                // The root holds the largest free capacity of any bin.
                if (r_amt > r_rdata) begin
                    n_room    = '0;
                    n_granted = 1'b0;
                    n_state   = S_RESULT;
                end else begin
                    n_node    = t_node'(1);
                    mem_raddr = t_node'(2);
                    n_state   = S_DESC;
                end
            end
            S_DESC: begin
                // The read data is the left child of the current node.
                n_node = child;
                if (child[LEVELS]) begin
                    mem_raddr = child;
                    n_state   = S_LEAF;
                end else begin
                    mem_raddr = {child[NODE_BITS-2:0], 1'b0};
                end
            end
            S_LEAF: begin
                mem_we    = 1'b1;
                mem_wdata = r_rdata - r_amt;
                n_val     = r_rdata - r_amt;
                mem_raddr = sibling;
                n_room    = ROOM_W'(r_node[LEVELS-1:0]) + ROOM_W'(1);
                n_granted = 1'b1;
                n_state   = S_UP;
            end
            S_UP: begin
                // The read data is the sibling of the node just written.
                mem_we    = 1'b1;
                mem_waddr = ancestor;
                mem_wdata = up_max;
                n_val     = up_max;
                n_node    = ancestor;
                mem_raddr = ancestor ^ t_node'(1);
                if (ancestor == t_node'(1)) begin
                    n_state = r_alloc ? S_RESULT : S_IDLE;
                end
            end
            S_RESULT: begin
                if (!r_out_valid || o_rsp.ready) begin
                    n_out_valid   = 1'b1;
                    n_out_room    = r_room;
                    n_out_granted = r_granted;
                    n_state       = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_node      <= '0;
            r_alloc     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_node      <= n_node;
            r_alloc     <= n_alloc;
            r_out_valid <= n_out_valid;
        end
        r_val         <= n_val;
        r_amt         <= n_amt;
        r_room        <= n_room;
        r_granted     <= n_granted;
        r_out_room    <= n_out_room;
        r_out_granted <= n_out_granted;
    end

    assign i_req.ready   = (r_state == S_IDLE);
    assign o_rsp.valid   = r_out_valid;
    assign o_rsp.room    = r_out_room;
    assign o_rsp.granted = r_out_granted;

endmodule

[rtl/ffmta_chk.sv]
`include "first_fit_max_tree_allocator_top_assert.svh"

module ffmta_chk (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_req_valid,
    input logic                        i_req_ready,
    input logic                        i_rsp_valid,
    input logic                        i_rsp_ready,
    input logic [ffmta_pkg::ROOM_W-1:0] i_rsp_room,
    input logic                        i_rsp_granted
);
    import ffmta_pkg::*;

    // A stalled result keeps its payload.
    `FFMTA_ASSERT(a_rsp_hold, i_clk, i_rst_n, i_rsp_valid && !i_rsp_ready |=> i_rsp_valid && $stable(i_rsp_room) && $stable(i_rsp_granted), "stalled result changed")

    // A refused request always reports room zero.
    `FFMTA_ASSERT(a_no_room, i_clk, i_rst_n, i_rsp_valid && !i_rsp_granted |-> i_rsp_room == '0, "refused request with nonzero room")

    // A granted bin number never lies beyond the last bin.
    `FFMTA_ASSERT(a_room_range, i_clk, i_rst_n, i_rsp_valid && i_rsp_granted |-> i_rsp_room <= BINS, "granted room out of range")

    // The block works on one request at a time.
    `FFMTA_ASSERT(a_busy_after_accept, i_clk, i_rst_n, i_req_valid && i_req_ready |=> !i_req_ready, "ready right after an accepted request")

    // The clearing pass keeps requests out right after reset.
    `FFMTA_ASSERT_ALWAYS(a_clear_after_reset, i_clk, !i_rst_n |=> !i_req_ready, "ready during the clearing pass")

endmodule

bind first_fit_max_tree_allocator_top ffmta_chk u_ffmta_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_req_valid   (i_req.valid),
    .i_req_ready   (i_req.ready),
    .i_rsp_valid   (o_rsp.valid),
    .i_rsp_ready   (o_rsp.ready),
    .i_rsp_room    (o_rsp.room),
    .i_rsp_granted (o_rsp.granted)
);
